/* rtl/core/eske_pkg.sv */
package eske_pkg;

    // Widths of the fixed-point datapath.
    localparam int X_W     = 21;   // argument, signed Q4.16
    localparam int BETA_W  = 22;   // beta, unsigned Q6.16
    localparam int C_W     = 25;   // c, unsigned Q1.24
    localparam int R_W     = 57;   // radicand, Q0.56 up to and including 1.0
    localparam int RES_W   = 58;   // working root of the bit-by-bit square root
    localparam int S_W     = 29;   // root, Q0.28 up to and including 1.0
    localparam int T_W     = 51;   // beta times root, Q7.44
    localparam int K_W     = 7;    // integer part of t / ln2
    localparam int F_W     = 32;   // fractional remainder, Q0.32
    localparam int TERM_W  = 33;   // Taylor term, Q1.32
    localparam int SUM_W   = 34;   // Taylor sum
    localparam int OUT_W   = 63;   // result, unsigned Q47.16
    localparam int CFG_W   = 25;   // configuration write data
    localparam int IDX_W   = 2;    // configuration register index

    localparam int ROOT_STEPS   = 29;
    localparam int DIV_STEPS    = 7;
    localparam int TAYLOR_TERMS = 13;

    localparam logic [43:0]        LN2_Q44  = 44'hB17217F7D1D;
    localparam logic [R_W-1:0]     ONE_Q56  = R_W'(1) << 56;
    localparam logic [TERM_W-1:0]  ONE_Q32  = TERM_W'(1) << 32;
    localparam logic [OUT_W-1:0]   OUT_MAX  = {OUT_W{1'b1}};
    localparam logic [K_W-1:0]     K_SAT    = K_W'(47);
    localparam logic [K_W-1:0]     K_UNITY  = K_W'(16);

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_BETA_SHAPE = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SCALE_C    = IDX_W'(1);

    // Sideband that travels with every item along the chain.
    typedef struct packed {
        logic           valid;
        logic           last;
        logic           clamped;
        logic [K_W-1:0] k;
    } side_t;

endpackage

/* rtl/core/eske_root_cell.sv */
module eske_root_cell #(
    parameter int STEP = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  eske_pkg::side_t           side_in,
    input  logic [eske_pkg::R_W-1:0]  rem_in,
    input  logic [eske_pkg::RES_W-1:0] res_in,
    output eske_pkg::side_t           side_out,
    output logic [eske_pkg::R_W-1:0]  rem_out,
    output logic [eske_pkg::RES_W-1:0] res_out
);
    import eske_pkg::*;

    // One result bit of the restoring square root per cell.
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (56 - 2 * STEP);

    side_t             side_reg;
    logic [R_W-1:0]    rem_reg;
    logic [RES_W-1:0]  res_reg;
    logic [RES_W-1:0]  trial;
    logic              take;
    logic [R_W-1:0]    rem_next;
    logic [RES_W-1:0]  res_next;

    always_comb
    begin
        trial    = res_in + BIT;
        take     = ({1'b0, rem_in} >= trial);
        rem_next = take ? (rem_in - trial[R_W-1:0]) : rem_in;
        res_next = take ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign res_out  = res_reg;

endmodule

/* rtl/core/eske_div_cell.sv */
module eske_div_cell #(
    parameter int J = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  eske_pkg::side_t           side_in,
    input  logic [eske_pkg::T_W-1:0]  rem_in,
    output eske_pkg::side_t           side_out,
    output logic [eske_pkg::T_W-1:0]  rem_out
);
    import eske_pkg::*;

    // Quotient bit J of t / ln2, restoring division by a constant.
    localparam logic [T_W-1:0] DIVISOR = T_W'(LN2_Q44) << J;

    side_t          side_reg;
    side_t          side_next;
    logic [T_W-1:0] rem_reg;
    logic [T_W-1:0] rem_next;
    logic           take;

    always_comb
    begin
        take         = (rem_in >= DIVISOR);
        rem_next     = take ? (rem_in - DIVISOR) : rem_in;
        side_next    = side_in;
        side_next.k[J] = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
        end
    end

    assign side_out = side_reg;
    assign rem_out  = rem_reg;

endmodule

/* rtl/core/eske_taylor_cell.sv */
module eske_taylor_cell #(
    parameter int N = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  eske_pkg::side_t              side_in,
    input  logic [eske_pkg::F_W-1:0]     f_in,
    input  logic [eske_pkg::TERM_W-1:0]  term_in,
    input  logic [eske_pkg::SUM_W-1:0]   sum_in,
    output eske_pkg::side_t              side_out,
    output logic [eske_pkg::F_W-1:0]     f_out,
    output logic [eske_pkg::TERM_W-1:0]  term_out,
    output logic [eske_pkg::SUM_W-1:0]   sum_out
);
    import eske_pkg::*;

    // Division by N is a multiply by floor(2^36 / N) and one correction step.
    localparam int              RSH   = 36;
    localparam logic [36:0]     RECIP = 37'((64'd1 << RSH) / N);
    localparam logic [TERM_W-1:0] NQ  = TERM_W'(N);

    // Stage A: product with f.
    side_t                side_a_reg;
    logic [F_W-1:0]       f_a_reg;
    logic [SUM_W-1:0]     sum_a_reg;
    logic [TERM_W-1:0]    pr_a_reg;
    logic [64:0]          prod;

    // Stage B: reciprocal multiply.
    side_t                side_b_reg;
    logic [F_W-1:0]       f_b_reg;
    logic [SUM_W-1:0]     sum_b_reg;
    logic [TERM_W-1:0]    pr_b_reg;
    logic [TERM_W-1:0]    q_b_reg;
    logic [69:0]          qm;

    // Stage C: correction and accumulation.
    side_t                side_c_reg;
    logic [F_W-1:0]       f_c_reg;
    logic [SUM_W-1:0]     sum_c_reg;
    logic [TERM_W-1:0]    term_c_reg;
    logic [TERM_W-1:0]    rem;
    logic [TERM_W-1:0]    term_next;
    logic [SUM_W-1:0]     sum_next;

    always_comb
    begin
        prod      = term_in * f_in;
        qm        = pr_a_reg * RECIP;
        rem       = pr_b_reg - TERM_W'(q_b_reg * NQ);
        term_next = q_b_reg + TERM_W'(rem >= NQ);
        sum_next  = sum_b_reg + SUM_W'(term_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
        end
        else if (en)
        begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_a_reg    <= f_in;
            sum_a_reg  <= sum_in;
            pr_a_reg   <= prod[64:32];
            f_b_reg    <= f_a_reg;
            sum_b_reg  <= sum_a_reg;
            pr_b_reg   <= pr_a_reg;
            q_b_reg    <= qm[RSH+TERM_W-1:RSH];
            f_c_reg    <= f_b_reg;
            sum_c_reg  <= sum_next;
            term_c_reg <= term_next;
        end
    end

    assign side_out = side_c_reg;
    assign f_out    = f_c_reg;
    assign term_out = term_c_reg;
    assign sum_out  = sum_c_reg;

endmodule

/* rtl/core/es_kernel_evaluator.sv */
// Exponential-of-semicircle kernel evaluator: exp(beta * sqrt(1 - c*x*x)).
// Arguments enter on the in channel (arg_x signed Q4.16, arg_last marker) with
// in_valid/in_ready; each transfer yields exactly one result on the out channel
// (kernel_value unsigned Q47.16 plus the radicand_clamped, value_saturated and
// result_last flags) with out_valid/out_ready. beta_shape and scale_c are set
// through cfg_we/cfg_index/cfg_wdata while no argument is in flight; the user
// must keep to this, since the block itself does not enforce it. An argument
// passes the registers for the square of x, the product with c and the
// radicand, 29 square-root cells, the register for beta times the root, 7
// division cells for the split by ln2, 13 Taylor cells of three stages each
// and the output register. Throughput is one argument per cycle while the
// chain is not held, and every cell then takes a new item each cycle.
// Reset clears both configuration registers and all valid flags but no data
// register of the chain. When the receiver stalls, the finished result waits in
// the output register while the chain keeps moving as long as its last cell is
// empty, so new transfers are still taken; once a result reaches the end of the
// chain behind the waiting one, the whole chain holds and in_ready falls.
module es_kernel_evaluator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [eske_pkg::IDX_W-1:0]    cfg_index,
    input  logic [eske_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [eske_pkg::X_W-1:0] arg_x,
    input  logic                          arg_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [eske_pkg::OUT_W-1:0]    kernel_value,
    output logic                          radicand_clamped,
    output logic                          value_saturated,
    output logic                          result_last
);
    import eske_pkg::*;

    // Configuration registers.
    logic [BETA_W-1:0] beta_reg;
    logic [C_W-1:0]    scale_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg    <= '0;
            scale_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BETA_SHAPE: beta_reg    <= cfg_wdata[BETA_W-1:0];
                REG_SCALE_C:    scale_c_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Chain advance: the chain moves whenever the output register can take
    // what leaves the last cell, or the last cell is empty.
    side_t taylor_side [TAYLOR_TERMS+1];
    logic  out_free;
    logic  en;
    logic  out_valid_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign en       = out_free || !taylor_side[TAYLOR_TERMS].valid;
    assign in_ready = en;

    // Stage 1: magnitude of x and its square.
    side_t             s1_side_reg;
    logic [X_W-1:0]    mag;
    logic [40:0]       p_reg;

    assign mag = arg_x[X_W-1] ? (X_W'(0) - arg_x) : arg_x;

    // Stage 2: c times the square, split into high and low halves.
    side_t             s2_side_reg;
    logic [33:0]       hi_reg;
    logic [56:0]       lo_reg;

    // Stage 3: radicand with clamping.
    side_t             s3_side_reg;
    logic [R_W-1:0]    r_reg;
    logic [57:0]       prod_full;
    logic              neg_hi;
    logic              neg_lo;
    side_t             s3_side_next;
    logic [R_W-1:0]    r_next;

    always_comb
    begin
        prod_full    = {hi_reg[25:0], 32'd0} + {1'b0, lo_reg};
        neg_hi       = (hi_reg > 34'(1 << 24));
        neg_lo       = (prod_full > 58'(ONE_Q56));
        s3_side_next = s2_side_reg;
        s3_side_next.clamped = neg_hi || neg_lo;
        r_next       = (neg_hi || neg_lo) ? '0 : (ONE_Q56 - prod_full[R_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
        end
        else if (en)
        begin
            s1_side_reg <= '{valid: in_valid, last: arg_last, clamped: 1'b0, k: '0};
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s3_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= 41'(mag * mag);
            hi_reg <= 34'(scale_c_reg * p_reg[40:32]);
            lo_reg <= 57'(scale_c_reg * p_reg[31:0]);
            r_reg  <= r_next;
        end
    end

    // Square root, one result bit per cell.
    side_t            root_side [ROOT_STEPS+1];
    logic [R_W-1:0]   root_rem  [ROOT_STEPS+1];
    logic [RES_W-1:0] root_res  [ROOT_STEPS+1];

    assign root_side[0] = s3_side_reg;
    assign root_rem[0]  = r_reg;
    assign root_res[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ROOT_STEPS; gi++)
        begin : g_root
            eske_root_cell #(.STEP(gi)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .side_in  (root_side[gi]),
                .rem_in   (root_rem[gi]),
                .res_in   (root_res[gi]),
                .side_out (root_side[gi+1]),
                .rem_out  (root_rem[gi+1]),
                .res_out  (root_res[gi+1])
            );
        end
    endgenerate

    // beta times the root.
    side_t          t_side_reg;
    logic [T_W-1:0] t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_side_reg <= '0;
        end
        else if (en)
        begin
            t_side_reg <= root_side[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= T_W'(beta_reg * root_res[ROOT_STEPS][S_W-1:0]);
        end
    end

    // Split t into k * ln2 plus a remainder, most significant quotient bit first.
    side_t          div_side [DIV_STEPS+1];
    logic [T_W-1:0] div_rem  [DIV_STEPS+1];

    assign div_side[0] = t_side_reg;
    assign div_rem[0]  = t_reg;

    generate
        for (gi = 0; gi < DIV_STEPS; gi++)
        begin : g_div
            eske_div_cell #(.J(DIV_STEPS - 1 - gi)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .side_in  (div_side[gi]),
                .rem_in   (div_rem[gi]),
                .side_out (div_side[gi+1]),
                .rem_out  (div_rem[gi+1])
            );
        end
    endgenerate

    // exp of the remainder as a Taylor sum, one term per cell.
    logic [F_W-1:0]    taylor_f    [TAYLOR_TERMS+1];
    logic [TERM_W-1:0] taylor_term [TAYLOR_TERMS+1];
    logic [SUM_W-1:0]  taylor_sum  [TAYLOR_TERMS+1];

    assign taylor_side[0] = div_side[DIV_STEPS];
    assign taylor_f[0]    = div_rem[DIV_STEPS][F_W+11:12];
    assign taylor_term[0] = ONE_Q32;
    assign taylor_sum[0]  = SUM_W'(ONE_Q32);

    generate
        for (gi = 0; gi < TAYLOR_TERMS; gi++)
        begin : g_taylor
            eske_taylor_cell #(.N(gi + 1)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .side_in  (taylor_side[gi]),
                .f_in     (taylor_f[gi]),
                .term_in  (taylor_term[gi]),
                .sum_in   (taylor_sum[gi]),
                .side_out (taylor_side[gi+1]),
                .f_out    (taylor_f[gi+1]),
                .term_out (taylor_term[gi+1]),
                .sum_out  (taylor_sum[gi+1])
            );
        end
    endgenerate

    // Scale by 2^k into Q47.16 and saturate.
    side_t            fin_side;
    logic [OUT_W-1:0] e_wide;
    logic [OUT_W-1:0] value_next;
    logic             sat_next;
    logic [OUT_W-1:0] value_reg;
    logic             clamped_reg;
    logic             sat_reg;
    logic             last_reg;

    always_comb
    begin
        fin_side = taylor_side[TAYLOR_TERMS];
        e_wide   = OUT_W'(taylor_sum[TAYLOR_TERMS]);
        sat_next = (fin_side.k >= K_SAT);
        if (sat_next)
        begin
            value_next = OUT_MAX;
        end
        else if (fin_side.k >= K_UNITY)
        begin
            value_next = e_wide << (fin_side.k - K_UNITY);
        end
        else
        begin
            value_next = e_wide >> (K_UNITY - fin_side.k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fin_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            value_reg   <= value_next;
            clamped_reg <= fin_side.clamped;
            sat_reg     <= sat_next;
            last_reg    <= fin_side.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kernel_value     = value_reg;
    assign radicand_clamped = clamped_reg;
    assign value_saturated  = sat_reg;
    assign result_last      = last_reg;

endmodule

/* dv/es_kernel_evaluator_tb.sv */
`timescale 1ns / 100ps

module es_kernel_evaluator_tb;

    import eske_pkg::*;

    // Indexes beyond the two implemented registers; writes to them must be ignored.
    localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int LONG_HOLD      = 400;

    // One result as the output channel presents it.
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             clamped;
        logic             saturated;
        logic             last;
    } kernel_result_t;

    // The scoreboard keeps its own copy of the two registers, works out the
    // kernel value for every argument transfer and compares the results in order.
    class kernel_scoreboard;
        logic [BETA_W-1:0] beta_copy;
        logic [C_W-1:0]    scale_copy;
        kernel_result_t    due_q[$];
        int                errors;
        int                checked;
        int                clamp_seen;
        int                sat_seen;

        function new();
            beta_copy  = '0;
            scale_copy = '0;
            errors     = 0;
            checked    = 0;
            clamp_seen = 0;
            sat_seen   = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_BETA_SHAPE)
                beta_copy = data[BETA_W-1:0];
            else if (idx == REG_SCALE_C)
                scale_copy = data[C_W-1:0];
        endfunction

        // Bit-by-bit integer square root of a Q0.56 radicand, giving Q0.28.
        function logic [63:0] isqrt(logic [63:0] r);
            logic [63:0] res;
            logic [63:0] bit_w;
            res   = 0;
            bit_w = 64'd1 << 56;
            while (bit_w > r)
                bit_w = bit_w >> 2;
            while (bit_w != 0)
            begin
                if (r >= res + bit_w)
                begin
                    r   = r - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        function kernel_result_t evaluate(logic [X_W-1:0] x, logic last);
            kernel_result_t rv;
            logic [63:0] mag, p, hi, lo, prod, r, s, t, k, f, e, term;
            mag = x[X_W-1] ? (64'h200000 - 64'(x)) : 64'(x);
            p   = mag * mag;
            hi  = 64'(scale_copy) * (p >> 32);
            lo  = 64'(scale_copy) * (p & 64'hFFFF_FFFF);
            rv.clamped = 1'b0;
            r = 0;
            if (hi > (64'd1 << 24))
                rv.clamped = 1'b1;
            else
            begin
                prod = (hi << 32) + lo;
                if (prod > (64'd1 << 56))
                    rv.clamped = 1'b1;
                else
                    r = (64'd1 << 56) - prod;
            end
            s = isqrt(r);
            t = 64'(beta_copy) * s;
            k = t / 64'(LN2_Q44);
            f = (t - k * 64'(LN2_Q44)) >> 12;
            // Thirteen truncated Taylor terms of exp(f) in Q1.32.
            term = 64'd1 << 32;
            e    = term;
            for (int n = 1; n <= TAYLOR_TERMS; n++)
            begin
                term = ((term * f) >> 32) / 64'(n);
                e    = e + term;
            end
            rv.saturated = 1'b0;
            if (k >= 47)
            begin
                rv.saturated = 1'b1;
                rv.value     = OUT_MAX;
            end
            else if (k >= 16)
                rv.value = OUT_W'(e << (k - 16));
            else
                rv.value = OUT_W'(e >> (16 - k));
            rv.last = last;
            return rv;
        endfunction

        function void note_argument(logic [X_W-1:0] x, logic last);
            due_q.push_back(evaluate(x, last));
        endfunction

        function void check_result(kernel_result_t got);
            kernel_result_t want;
            if (due_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: value %h", $time, got.value);
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            if (got.clamped)
                clamp_seen++;
            if (got.saturated)
                sat_seen++;
            if (got.value !== want.value)
            begin
                $display("%0t: kernel_value expected %h actual %h", $time, want.value,
                         got.value);
                errors++;
            end
            if (got.clamped !== want.clamped)
            begin
                $display("%0t: radicand_clamped expected %b actual %b", $time,
                         want.clamped, got.clamped);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: value_saturated expected %b actual %b", $time,
                         want.saturated, got.saturated);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: result_last expected %b actual %b", $time, want.last,
                         got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [X_W-1:0] arg_x;
    logic                  arg_last;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUT_W-1:0]      kernel_value;
    logic                  radicand_clamped;
    logic                  value_saturated;
    logic                  result_last;

    kernel_scoreboard sb;
    int  idle_cycles;
    bit  hold_request;
    int  burst_left;

    es_kernel_evaluator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .arg_x            (arg_x),
        .arg_last         (arg_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kernel_value     (kernel_value),
        .radicand_clamped (radicand_clamped),
        .value_saturated  (value_saturated),
        .result_last      (result_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // All inputs change only at rising edges, so at the falling edge every
    // handshake signal is settled. Both monitors sample there: a transfer seen
    // at a falling edge completes at the rising edge that follows.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_argument(arg_x, arg_last);
            if (out_valid && out_ready)
                sb.check_result({kernel_value, radicand_clamped, value_saturated,
                                 result_last});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding", $time,
                         sb.due_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // The receiver changes its manner of stalling after each random stretch.
    // A hold request makes it refuse every result for a long stretch, so that
    // the chain fills behind the waiting result and in_ready has to fall.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        out_ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= (mode_left % 8) < 3;
                endcase
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Registers may only change with nothing in flight: wait for the last
    // result, then for rather more than the chain latency.
    task automatic settle();
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [CFG_W-1:0] beta, logic [CFG_W-1:0] scale);
        settle();
        write_reg(REG_BETA_SHAPE, beta);
        write_reg(REG_SCALE_C, scale);
    endtask

    // Offers one argument and holds it until the transfer completes. The
    // sender works in bursts, and between most bursts in_valid drops.
    task automatic send_arg(logic [X_W-1:0] x, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        arg_x    <= x;
        arg_last <= last;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
    endtask

    function automatic logic [X_W-1:0] random_arg();
        logic [X_W-1:0] x;
        // Half the arguments stay near the unit interval where the radicand
        // is positive for the usual c; the rest span the whole field.
        if ($urandom_range(0, 1) == 0)
            x = X_W'($urandom_range(0, 70000));
        else
            x = X_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            x = -x;
        return x;
    endfunction

    task automatic random_phase(int count, bit pressure);
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == count / 3)
                hold_request = 1'b1;
            send_arg(random_arg(), ($urandom_range(0, 7) == 0));
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [X_W-1:0] unit_args[$];
        sb           = new();
        idle_cycles  = 0;
        hold_request = 1'b0;
        burst_left   = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        arg_x     <= '0;
        arg_last  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. With beta 32 and c 1.0, x = +-1.0 gives a radicand of
        // exactly zero with no flag, anything beyond it clamps, and x = 0 gives
        // the largest value that still fits.
        configure(CFG_W'(2097152), CFG_W'(16777216));
        unit_args = '{X_W'(0), X_W'(65536), -X_W'(65536), X_W'(65537), -X_W'(65537),
                      X_W'(65535), X_W'(1048575), X_W'(1048576), X_W'(1), -X_W'(1),
                      X_W'(32768), -X_W'(32768)};
        foreach (unit_args[i])
            send_arg(unit_args[i], i[0]);
        in_valid <= 1'b0;

        // Writes to the unused indexes must leave both registers alone.
        settle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, CFG_W'($urandom));
        send_arg(X_W'(0), 1'b1);
        in_valid <= 1'b0;

        // Beta at its maximum saturates the output; c at zero never clamps.
        configure(CFG_W'(22'h3FFFFF), CFG_W'(0));
        send_arg(X_W'(0), 1'b0);
        send_arg(X_W'(1048575), 1'b0);
        send_arg(X_W'(1048576), 1'b1);
        in_valid <= 1'b0;

        // Beta zero gives exactly 1.0 everywhere; c at its widest clamps almost all.
        configure(CFG_W'(0), CFG_W'(25'h1FFFFFF));
        send_arg(X_W'(0), 1'b0);
        send_arg(X_W'(1), 1'b0);
        send_arg(X_W'(1048575), 1'b1);
        in_valid <= 1'b0;

        // Random part over several settings, extremes among them.
        configure(CFG_W'(2097152), CFG_W'(16777216));
        random_phase(330, 1'b1);
        configure(CFG_W'(0), CFG_W'(0));
        random_phase(260, 1'b0);
        configure(CFG_W'(22'h3FFFFF), CFG_W'(25'h1FFFFFF));
        random_phase(260, 1'b0);
        for (int ph = 0; ph < 4; ph++)
        begin
            configure(CFG_W'($urandom_range(0, 2097152)),
                      CFG_W'($urandom_range(0, 16777216)));
            random_phase(275, 1'b0);
        end

        settle();
        $display("Checked %0d kernel results across ten register settings, directed and random;",
                 sb.checked);
        $display("%0d had a clamped radicand and %0d a saturated value.", sb.clamp_seen,
                 sb.sat_seen);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
